FILE: design/fwmh_pkg.sv
// Package for the four-way min-heap: operation, status and sequencer codes
// plus the fixed field widths of the stream beats. No dependencies.
`timescale 1ns / 1ps

package fwmh_pkg;

	localparam int KEY_W      = 32;
	localparam int TAG_IN_W   = 16;
	localparam int CNT_OUT_W  = 11;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 64;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_PEEK   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_PAR,
		S_UP_RD,
		S_UP_CMP,
		S_UP_PUT,
		S_DN_ROOT,
		S_DN_LAST,
		S_DN_START,
		S_DN_SCAN,
		S_PK_RD,
		S_FINISH
	} state_t;

endpackage

FILE: design/four_way_min_heap.sv
// Insert: S_UP_PAR, S_UP_RD and S_UP_CMP per parent, S_UP_PUT at the root. Delete:
// root and last reads, then up to ARITY child reads per node going down. Peek reads
// root; clear and rejected ops go to S_FINISH. A stalled result beat delays the
// finish. One operation is in flight; the result register lets the next beat start.
// arst_n clears the sequencer, entry count and output valid; store is not cleared.
// Depends on fwmh_pkg, fwmh_mem and fwmh_par.
`timescale 1ns / 1ps

module four_way_min_heap import fwmh_pkg::*; #(
	parameter int CAPACITY  = 1024,
	parameter int ARITY     = 4,
	parameter int TAG_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [1:0]            s_tuser,  // mode
	input  logic [IN_DATA_W-1:0]  s_tdata,  // key, tag
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // out_key, out_tag, status, entry_count
);

	localparam int IW    = $clog2(CAPACITY);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int XW    = IW + $clog2(ARITY) + 1;
	localparam int CIW   = $clog2(ARITY + 1);
	localparam int TKEEP = (TAG_WIDTH < TAG_IN_W) ? TAG_WIDTH : TAG_IN_W;
	localparam int EW    = KEY_W + TAG_WIDTH;

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic out_valid_q, out_load;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [IW-1:0]        pos_q, pos_d;
	logic [KEY_W-1:0]     key_q, key_d;
	logic [TAG_WIDTH-1:0] tag_q, tag_d;
	logic [CIW-1:0]       cidx_q, cidx_d;
	logic [IW-1:0]        rd_idx_q, rd_idx_d;
	logic [IW-1:0]        best_idx_q, best_idx_d;
	logic [KEY_W-1:0]     best_key_q, best_key_d;
	logic [TAG_WIDTH-1:0] best_tag_q, best_tag_d;
	logic [KEY_W-1:0]     res_key_q, res_key_d;
	logic [TAG_IN_W-1:0]  res_tag_q, res_tag_d;
	status_t              res_st_q, res_st_d;

	logic          mem_we;
	logic [IW-1:0] mem_waddr, mem_raddr;
	logic [EW-1:0] mem_wdata, mem_rdata;
	logic [IW-1:0] par;

	mode_t               in_mode;
	logic [KEY_W-1:0]    in_key;
	logic [TAG_IN_W-1:0] in_tag;

	logic [KEY_W-1:0]     rd_key, nb_key;
	logic [TAG_WIDTH-1:0] rd_tag, nb_tag;
	logic [IW-1:0]        nb_idx, last_idx;
	logic                 take_rd;
	logic [XW-1:0]        first_x, next_x, cnt_x;

	assign in_mode = mode_t'(s_tuser);
	assign in_key  = s_tdata[KEY_W-1:0];
	assign in_tag  = s_tdata[KEY_W +: TAG_IN_W];

	assign rd_key   = mem_rdata[KEY_W-1:0];
	assign rd_tag   = mem_rdata[EW-1:KEY_W];
	assign take_rd  = (cidx_q == CIW'(1)) || (rd_key < best_key_q);
	assign nb_key   = take_rd ? rd_key : best_key_q;
	assign nb_tag   = take_rd ? rd_tag : best_tag_q;
	assign nb_idx   = take_rd ? rd_idx_q : best_idx_q;
	assign last_idx = IW'(cnt_q - CW'(1));
	assign first_x  = XW'(ARITY) * XW'(pos_q) + XW'(1);
	assign next_x   = first_x + XW'(cidx_q);
	assign cnt_x    = XW'(cnt_q);

	fwmh_mem #(
		.DEPTH(CAPACITY),
		.WIDTH(EW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	fwmh_par #(
		.IW   (IW),
		.ARITY(ARITY)
	) u_par (
		.clk(clk),
		.pos(pos_q),
		.par(par)
	);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		pos_d      = pos_q;
		key_d      = key_q;
		tag_d      = tag_q;
		cidx_d     = cidx_q;
		rd_idx_d   = rd_idx_q;
		best_idx_d = best_idx_q;
		best_key_d = best_key_q;
		best_tag_d = best_tag_q;
		res_key_d  = res_key_q;
		res_tag_d  = res_tag_q;
		res_st_d   = res_st_q;
		mem_we     = 1'b0;
		mem_waddr  = pos_q;
		mem_wdata  = {tag_q, key_q};
		mem_raddr  = '0;
		out_load   = 1'b0;
		s_tready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					res_key_d = '0;
					res_tag_d = '0;
					res_st_d  = STAT_OK;
					key_d     = in_key;
					tag_d     = TAG_WIDTH'(in_tag[TKEEP-1:0]);
					state_d   = S_FINISH;
					unique case (in_mode)
						MODE_INSERT: begin
							if (cnt_q == CW'(CAPACITY)) begin
								res_st_d = STAT_FULL;
							end else begin
								pos_d   = cnt_q[IW-1:0];
								cnt_d   = cnt_q + CW'(1);
								state_d = (cnt_q == '0) ? S_UP_PUT : S_UP_PAR;
							end
						end
						MODE_DELETE: begin
							if (cnt_q == '0) begin
								res_st_d = STAT_EMPTY;
							end else begin
								state_d = S_DN_ROOT;
							end
						end
						MODE_PEEK: begin
							if (cnt_q == '0) begin
								res_st_d = STAT_EMPTY;
							end else begin
								state_d = S_PK_RD;
							end
						end
						MODE_CLEAR: begin
							cnt_d = '0;
						end
						default: begin
							state_d = S_FINISH;
						end
					endcase
				end
			end
			S_UP_PAR: begin
				state_d = S_UP_RD;
			end
			S_UP_RD: begin
				mem_raddr = par;
				state_d   = S_UP_CMP;
			end
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (key_q < rd_key) begin
					mem_wdata = mem_rdata;
					pos_d     = par;
					state_d   = (par == '0) ? S_UP_PUT : S_UP_PAR;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_UP_PUT: begin
				mem_we  = 1'b1;
				state_d = S_FINISH;
			end
			S_DN_ROOT: begin
				res_key_d = rd_key;
				res_tag_d = TAG_IN_W'(rd_tag[TKEEP-1:0]);
				mem_raddr = last_idx;
				cnt_d     = cnt_q - CW'(1);
				state_d   = S_DN_LAST;
			end
			S_DN_LAST: begin
				key_d   = rd_key;
				tag_d   = rd_tag;
				pos_d   = '0;
				state_d = (cnt_q == '0) ? S_FINISH : S_DN_START;
			end
			S_DN_START: begin
				if (first_x >= cnt_x) begin
					mem_we  = 1'b1;
					state_d = S_FINISH;
				end else begin
					mem_raddr = first_x[IW-1:0];
					rd_idx_d  = first_x[IW-1:0];
					cidx_d    = CIW'(1);
					state_d   = S_DN_SCAN;
				end
			end
			S_DN_SCAN: begin
				best_key_d = nb_key;
				best_tag_d = nb_tag;
				best_idx_d = nb_idx;
				if ((cidx_q < CIW'(ARITY)) && (next_x < cnt_x)) begin
					mem_raddr = next_x[IW-1:0];
					rd_idx_d  = next_x[IW-1:0];
					cidx_d    = cidx_q + CIW'(1);
				end else if (nb_key < key_q) begin
					mem_we    = 1'b1;
					mem_wdata = {nb_tag, nb_key};
					pos_d     = nb_idx;
					state_d   = S_DN_START;
				end else begin
					mem_we  = 1'b1;
					state_d = S_FINISH;
				end
			end
			S_PK_RD: begin
				res_key_d = rd_key;
				res_tag_d = TAG_IN_W'(rd_tag[TKEEP-1:0]);
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q      <= pos_d;
		key_q      <= key_d;
		tag_q      <= tag_d;
		cidx_q     <= cidx_d;
		rd_idx_q   <= rd_idx_d;
		best_idx_q <= best_idx_d;
		best_key_q <= best_key_d;
		best_tag_q <= best_tag_d;
		res_key_q  <= res_key_d;
		res_tag_q  <= res_tag_d;
		res_st_q   <= res_st_d;
		if (out_load) begin
			out_data_q <= OUT_DATA_W'({CNT_OUT_W'(cnt_q), res_st_q, res_tag_q, res_key_q});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: design/fwmh_mem.sv
// Heap entry store: one write port and one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fwmh_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/fwmh_par.sv
// Parent index unit: registered (pos - 1) / ARITY by reciprocal multiplication.
// No dependencies.
`timescale 1ns / 1ps

module fwmh_par #(
	parameter int IW    = 10,
	parameter int ARITY = 4
) (
	input  logic          clk,
	input  logic [IW-1:0] pos,
	output logic [IW-1:0] par
);

	localparam int     LA = $clog2(ARITY);
	localparam int     SH = IW + LA;
	localparam int     MW = IW + 2;
	localparam int     PW = IW + MW;
	localparam longint MV = ((64'd1 << SH) + ARITY - 1) / ARITY;
	localparam logic [MW-1:0] RECIP = MW'(MV);

	logic [IW-1:0] pm1;
	logic [PW-1:0] prod;

	assign pm1  = pos - IW'(1);
	assign prod = PW'(pm1) * PW'(RECIP);

	always_ff @(posedge clk) begin
		par <= IW'(prod >> SH);
	end

endmodule

FILE: design/fwmh_chk.sv
// Port-level checker for the four-way min-heap and its bind to the top level.
// Depends on fwmh_pkg and four_way_min_heap.
`timescale 1ns / 1ps

module fwmh_chk import fwmh_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [1:0]            s_tuser,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[49:48] == STAT_FULL) |->
		m_tdata[60:50] == CNT_OUT_W'(CAPACITY) && m_tdata[47:0] == '0)
		else $error("full status without a full heap");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[49:48] == STAT_EMPTY) |->
		m_tdata[60:50] == '0 && m_tdata[47:0] == '0)
		else $error("empty status without an empty heap");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[49:48] != 2'd3 && m_tdata[63:61] == '0)
		else $error("invalid status code or padding in result beat");

endmodule

bind four_way_min_heap fwmh_chk #(.CAPACITY(CAPACITY)) u_fwmh_chk (.*);

FILE: tb/heap_checker.sv
// Checker for the four-way min-heap: watches both stream channels, keeps its own
// heap to work out each result beat and compares every field. Depends on fwmh_pkg.
`timescale 1ns / 1ps

module heap_checker import fwmh_pkg::*; #(
	parameter int CAPACITY = 1024,
	parameter int ARITY    = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [1:0]            s_tuser,  // mode
	input  logic [IN_DATA_W-1:0]  s_tdata,  // key, tag
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,  // out_key, out_tag, status, entry_count
	output int                    err_count,
	output int                    outstanding
);

	typedef struct packed {
		logic [KEY_W-1:0]     key;
		logic [TAG_IN_W-1:0]  tag;
		status_t              st;
		logic [CNT_OUT_W-1:0] count;
	} heap_result_t;

	logic [KEY_W-1:0]    heap_key [CAPACITY];
	logic [TAG_IN_W-1:0] heap_tag [CAPACITY];
	int                  fill = 0;
	int                  fails = 0;
	heap_result_t        awaited_results [$];
	heap_result_t        want;
	heap_result_t        calc;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		$display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, exp_val);
		fails++;
	endtask

	task automatic heap_apply(input mode_t op, input logic [KEY_W-1:0] k,
			input logic [TAG_IN_W-1:0] t, output heap_result_t r);
		int pos;
		int par;
		int best;
		int cand;
		int c;
		logic [KEY_W-1:0] mk;
		logic [TAG_IN_W-1:0] mt;
		r = '0;
		r.st = STAT_OK;
		case (op)
			MODE_INSERT: begin
				if (fill >= CAPACITY) begin
					r.st = STAT_FULL;
				end else begin
					pos = fill;
					fill++;
					while (pos > 0) begin
						par = (pos - 1) / ARITY;
						if (!(k < heap_key[par]))
							break;
						heap_key[pos] = heap_key[par];
						heap_tag[pos] = heap_tag[par];
						pos = par;
					end
					heap_key[pos] = k;
					heap_tag[pos] = t;
				end
			end
			MODE_DELETE: begin
				if (fill == 0) begin
					r.st = STAT_EMPTY;
				end else begin
					r.key = heap_key[0];
					r.tag = heap_tag[0];
					mk = heap_key[fill - 1];
					mt = heap_tag[fill - 1];
					fill--;
					if (fill > 0) begin
						pos = 0;
						while (1'b1) begin
							if (ARITY * pos + 1 >= fill)
								break;
							best = ARITY * pos + 1;
							for (c = 2; c <= ARITY; c++) begin
								cand = ARITY * pos + c;
								if (cand >= fill)
									break;
								if (heap_key[cand] < heap_key[best])
									best = cand;
							end
							if (!(heap_key[best] < mk))
								break;
							heap_key[pos] = heap_key[best];
							heap_tag[pos] = heap_tag[best];
							pos = best;
						end
						heap_key[pos] = mk;
						heap_tag[pos] = mt;
					end
				end
			end
			MODE_PEEK: begin
				if (fill == 0) begin
					r.st = STAT_EMPTY;
				end else begin
					r.key = heap_key[0];
					r.tag = heap_tag[0];
				end
			end
			default: begin
				fill = 0;
			end
		endcase
		r.count = fill[CNT_OUT_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			awaited_results.delete();
			outstanding <= 0;
			err_count <= fails;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result beat", m_tdata, '0);
				end else begin
					want = awaited_results.pop_front();
					if (m_tdata[31:0] !== want.key)
						report_mismatch("out_key", 64'(m_tdata[31:0]), 64'(want.key));
					if (m_tdata[47:32] !== want.tag)
						report_mismatch("out_tag", 64'(m_tdata[47:32]), 64'(want.tag));
					if (m_tdata[49:48] !== want.st)
						report_mismatch("status", 64'(m_tdata[49:48]), 64'(want.st));
					if (m_tdata[60:50] !== want.count)
						report_mismatch("entry_count", 64'(m_tdata[60:50]),
							64'(want.count));
				end
			end
			if (s_tvalid && s_tready) begin
				heap_apply(mode_t'(s_tuser), s_tdata[31:0], s_tdata[47:32], calc);
				awaited_results = {awaited_results, calc};
			end
			outstanding <= awaited_results.size();
			err_count <= fails;
		end
	end

endmodule

FILE: tb/testbench.sv
// Top of the four-way min-heap testbench: clock, reset, stimulus and back pressure,
// with heap_checker beside the block doing all prediction and comparison.
// Depends on fwmh_pkg, heap_checker and four_way_min_heap.
`timescale 1ns / 1ps

module testbench import fwmh_pkg::*;;

	localparam int HEAP_DEPTH  = 1024;
	localparam int CYCLE_LIMIT = 1000000;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [1:0]            s_tuser = MODE_INSERT;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	int                    err_count;
	int                    outstanding;
	int                    cycle_count = 0;

	four_way_min_heap #(
		.CAPACITY(HEAP_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	heap_checker #(
		.CAPACITY(HEAP_DEPTH)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tuser     (s_tuser),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.err_count   (err_count),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int stall;
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, 12);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	function automatic logic [KEY_W-1:0] draw_key();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 15);
			1: return $urandom();
			2: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
			default: return $urandom_range(0, 1000);
		endcase
	endfunction

	task automatic send_beat(input mode_t op, input logic [KEY_W-1:0] k,
			input logic [TAG_IN_W-1:0] t);
		int gap;
		gap = $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {t, k};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random_op();
		int pick;
		mode_t op;
		pick = $urandom_range(0, 99);
		if (pick < 48)
			op = MODE_INSERT;
		else if (pick < 83)
			op = MODE_DELETE;
		else if (pick < 96)
			op = MODE_PEEK;
		else
			op = MODE_CLEAR;
		send_beat(op, draw_key(), 16'($urandom_range(0, 65535)));
	endtask

	initial begin
		int waited;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(MODE_DELETE, 32'h1234_5678, 16'h00FF);
		send_beat(MODE_PEEK, 32'hFFFF_FFFF, 16'hFFFF);
		send_beat(MODE_CLEAR, 32'h0, 16'h0);
		send_beat(MODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		send_beat(MODE_INSERT, 32'h0, 16'h0000);
		send_beat(MODE_INSERT, 32'h0, 16'h0001);
		send_beat(MODE_INSERT, 32'd5, 16'hAAAA);
		send_beat(MODE_INSERT, 32'd5, 16'h5555);
		send_beat(MODE_INSERT, 32'd3, 16'h1234);
		send_beat(MODE_INSERT, 32'hFFFF_FFFF, 16'h0000);
		send_beat(MODE_PEEK, 32'h0, 16'h0);
		repeat (4) send_beat(MODE_DELETE, 32'h0, 16'h0);
		send_beat(MODE_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
		send_beat(MODE_PEEK, 32'h0, 16'h0);
		send_beat(MODE_DELETE, 32'h0, 16'h0);
		send_beat(MODE_INSERT, 32'h8000_0000, 16'h8000);
		send_beat(MODE_PEEK, 32'h0, 16'h0);
		send_beat(MODE_DELETE, 32'h0, 16'h0);
		send_beat(MODE_DELETE, 32'h0, 16'h0);

		repeat (320) send_random_op();

		// Hold off until every result beat has drained.
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);

		repeat (60) send_random_op();

		s_tvalid <= 1'b0;
		waited = 0;
		while (outstanding != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (err_count == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
design/fwmh_pkg.sv
design/fwmh_mem.sv
design/fwmh_par.sv
design/four_way_min_heap.sv
design/fwmh_chk.sv
tb/heap_checker.sv
tb/testbench.sv
